// ===== hdl/sau_pkg.sv =====
// Shared types and constants for the stack arithmetic unit.
// Used by sau_ctrl, sau_dpath and stack_arithmetic_unit; depends on nothing.
`default_nettype none

package sau_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned DEPTH_W     = 7;
  localparam int unsigned STEP_W      = $clog2(WORD_W);

  localparam int unsigned KIND_W      = 3;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = ((WORD_W + DEPTH_W + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH = 3'd0,
    KIND_ADD  = 3'd1,
    KIND_SUB  = 3'd2,
    KIND_DIV  = 3'd3,
    KIND_MOD  = 3'd4,
    KIND_MUL  = 3'd5
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_DIVZERO = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    STK_NONE  = 2'd0,
    STK_PUSH  = 2'd1,
    STK_POP   = 2'd2,
    STK_CLEAR = 2'd3
  } stk_op_e;

  // Controller to datapath.
  typedef struct packed {
    logic            in_load;
    logic            alu_load;
    logic            div_start;
    logic            div_step;
    logic            commit;
    stk_op_e         stk_op;
    status_e         status;
  } sau_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              full;
    logic              short_stack;
    logic              top_zero;
    logic              div_last;
    logic              out_free;
  } sau_stat_t;

endpackage

`default_nettype wire

// ===== hdl/sau_ctrl.sv =====
// Controller state machine of the stack arithmetic unit.
// Sequences decode, divide steps and commit; depends on sau_pkg.
`default_nettype none

module sau_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire sau_pkg::sau_stat_t  stat_i,
  output sau_pkg::sau_cmd_t        cmd_o
);
  import sau_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_ALU    = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_q, state_d;
  stk_op_e    op_q, op_d;
  status_e    st_q, st_d;
  logic       is_div;

  assign in_ready_o = (state_q == S_IDLE);
  assign is_div = (stat_i.kind == KIND_DIV) || (stat_i.kind == KIND_MOD);

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    st_d    = st_q;
    cmd_o   = '0;
    cmd_o.stk_op = op_q;
    cmd_o.status = st_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_FINISH;
        op_d    = STK_NONE;
        st_d    = ST_OK;
        priority if (stat_i.kind == KIND_PUSH) begin
          if (stat_i.full) begin
            st_d = ST_FULL;
          end else begin
            op_d = STK_PUSH;
          end
        end else if (stat_i.kind == KIND_ADD || stat_i.kind == KIND_SUB ||
                     stat_i.kind == KIND_MUL || is_div) begin
          priority if (stat_i.short_stack) begin
            op_d = STK_CLEAR;
            st_d = ST_SHORT;
          end else if (is_div && stat_i.top_zero) begin
            op_d = STK_CLEAR;
            st_d = ST_DIVZERO;
          end else if (is_div) begin
            op_d = STK_POP;
            cmd_o.div_start = 1'b1;
            state_d = S_DIV;
          end else begin
            op_d = STK_POP;
            cmd_o.alu_load = 1'b1;
          end
        end else begin
          // Unused kinds leave the stack alone.
          op_d = STK_NONE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = S_ALU;
        end
      end
      S_ALU: begin
        cmd_o.alu_load = 1'b1;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= STK_NONE;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      st_q    <= st_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sau_dpath.sv =====
// Datapath of the stack arithmetic unit: stack memory, top-of-stack register,
// adder, multiplier, bit-serial divider and output register; depends on sau_pkg.
`default_nettype none

module sau_dpath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire sau_pkg::sau_cmd_t               cmd_i,
  output sau_pkg::sau_stat_t                   stat_o,
  input  wire logic [sau_pkg::KIND_W-1:0]      kind_i,
  input  wire logic [sau_pkg::WORD_W-1:0]      push_value_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [sau_pkg::STATUS_W-1:0]         status_o,
  output logic [sau_pkg::WORD_W-1:0]           top_value_o,
  output logic [sau_pkg::DEPTH_W-1:0]          stack_depth_o
);
  import sau_pkg::*;

  // The top entry lives in top_q; the memory holds the entries below it.
  logic [WORD_W-1:0] mem [STACK_DEPTH];
  logic [WORD_W-1:0] rd_q;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              wr_en;

  logic [KIND_W-1:0] kind_q;
  logic [WORD_W-1:0] pv_q;
  logic [WORD_W-1:0] top_q, top_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [WORD_W-1:0] res_q, res_d;
  logic [WORD_W-1:0] prod;

  logic [WORD_W-1:0] div_rem_q, div_quo_q, div_dsr_q;
  logic [STEP_W-1:0] div_cnt_q;
  logic              neg_a_q, neg_b_q;
  logic [WORD_W:0]   div_shift;
  logic              div_ge;

  logic              out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [WORD_W-1:0] out_top_q;
  logic [DEPTH_W-1:0] out_depth_q;

  assign rd_addr = ADDR_W'(count_q - CNT_W'(2));
  assign wr_addr = ADDR_W'(count_q - CNT_W'(1));
  assign wr_en   = cmd_i.commit && (cmd_i.stk_op == STK_PUSH) && (count_q != '0);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= top_q;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      kind_q <= kind_i;
      pv_q   <= push_value_i;
    end
  end

  assign prod = rd_q * top_q;

  always_comb begin
    unique case (kind_q)
      KIND_ADD: res_d = rd_q + top_q;
      KIND_SUB: res_d = rd_q - top_q;
      KIND_MUL: res_d = prod;
      KIND_DIV: res_d = (neg_a_q ^ neg_b_q) ? (WORD_W'(0) - div_quo_q) : div_quo_q;
      KIND_MOD: res_d = neg_a_q ? (WORD_W'(0) - div_rem_q) : div_rem_q;
      default:  res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.alu_load) begin
      res_q <= res_d;
    end
  end

  // Restoring divider on magnitudes, one quotient bit per cycle.
  assign div_shift = {div_rem_q, div_quo_q[WORD_W-1]};
  assign div_ge    = div_shift >= {1'b0, div_dsr_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      div_rem_q <= '0;
      div_quo_q <= rd_q[WORD_W-1] ? (WORD_W'(0) - rd_q) : rd_q;
      div_dsr_q <= top_q[WORD_W-1] ? (WORD_W'(0) - top_q) : top_q;
      div_cnt_q <= '0;
      neg_a_q   <= rd_q[WORD_W-1];
      neg_b_q   <= top_q[WORD_W-1];
    end else if (cmd_i.div_step) begin
      div_rem_q <= div_ge ? WORD_W'(div_shift - {1'b0, div_dsr_q})
                          : div_shift[WORD_W-1:0];
      div_quo_q <= {div_quo_q[WORD_W-2:0], div_ge};
      div_cnt_q <= div_cnt_q + STEP_W'(1);
    end
  end

  always_comb begin
    top_d   = top_q;
    count_d = count_q;
    unique case (cmd_i.stk_op)
      STK_PUSH: begin
        top_d   = pv_q;
        count_d = count_q + CNT_W'(1);
      end
      STK_POP: begin
        top_d   = res_q;
        count_d = count_q - CNT_W'(1);
      end
      STK_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      top_q <= top_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        count_q <= count_d;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_status_q <= cmd_i.status;
      out_top_q    <= (count_d == '0) ? '0 : top_d;
      out_depth_q  <= DEPTH_W'(count_d);
    end
  end

  assign stat_o.kind        = kind_q;
  assign stat_o.full        = (count_q >= CNT_W'(STACK_DEPTH));
  assign stat_o.short_stack = (count_q < CNT_W'(2));
  assign stat_o.top_zero    = (top_q == '0);
  assign stat_o.div_last    = (div_cnt_q == '1);
  assign stat_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign top_value_o   = out_top_q;
  assign stack_depth_o = out_depth_q;

endmodule

`default_nettype wire

// ===== hdl/stack_arithmetic_unit.sv =====
// Stack arithmetic unit: 64-entry operand stack with push, add, sub, div, mod, mul.
// Push, add, sub, mul and unused kinds go from decode straight to commit, where the result
// is registered; div and mod without an error first run the bit-serial divider (one bit per
// cycle). The next transaction is taken only after commit. A held result stalls the next commit.
// Reset (rst_ni low, asynchronous) empties the stack; stored words need no clearing.
// Depends on sau_pkg, sau_ctrl and sau_dpath.
`default_nettype none

module stack_arithmetic_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [sau_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [31:0] push_value
  input  wire logic [sau_pkg::KIND_W-1:0]          s_axis_tuser,  // [2:0] kind
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [31:0] top_value, [38:32] stack_depth, [39] zero
  output logic [sau_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
  output logic [sau_pkg::STATUS_W-1:0]             m_axis_tuser   // [1:0] status
);
  import sau_pkg::*;

  sau_cmd_t           cmd;
  sau_stat_t          stat;
  logic [WORD_W-1:0]  top_value;
  logic [DEPTH_W-1:0] stack_depth;

  sau_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sau_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .kind_i        (s_axis_tuser),
    .push_value_i  (s_axis_tdata),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .status_o      (m_axis_tuser),
    .top_value_o   (top_value),
    .stack_depth_o (stack_depth)
  );

  assign m_axis_tdata = OUT_TDATA_W'({stack_depth, top_value});

endmodule

`default_nettype wire

// ===== tb/stack_result_checker.sv =====
// Result checker for stack_arithmetic_unit: watches both stream channels, predicts
// each result from its own copy of the operand stack and compares field by field.
// Depends on sau_pkg for widths, operation kinds and status codes.
`default_nettype none

module stack_result_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  input  wire logic                            s_axis_tready_i,
  input  wire logic [sau_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,   // [31:0] push_value
  input  wire logic [sau_pkg::KIND_W-1:0]      s_axis_tuser_i,   // [2:0] kind
  input  wire logic                            m_axis_tvalid_i,
  input  wire logic                            m_axis_tready_i,
  // [31:0] top_value, [38:32] stack_depth
  input  wire logic [sau_pkg::OUT_TDATA_W-1:0] m_axis_tdata_i,
  input  wire logic [sau_pkg::STATUS_W-1:0]    m_axis_tuser_i,   // [1:0] status
  output int                                   fail_count_o,
  output int                                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sau_pkg::*;

  typedef struct packed {
    status_e              status;
    logic [WORD_W-1:0]    top;
    logic [DEPTH_W-1:0]   depth;
  } stack_result_t;

  logic [WORD_W-1:0] words [STACK_DEPTH];
  int unsigned       entries;
  stack_result_t     expected_q [$];
  stack_result_t     want;
  int                fails;

  // Applies one operation to the shadow stack and returns the result it reports.
  function automatic stack_result_t apply_item(input logic [KIND_W-1:0] kind,
                                               input logic [WORD_W-1:0] word);
    stack_result_t     res;
    logic [WORD_W-1:0] lhs, rhs, lhs_mag, rhs_mag, value;
    res.status = ST_OK;
    if (kind == KIND_PUSH) begin
      if (entries >= STACK_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        words[entries] = word;
        entries++;
      end
    end else if (kind <= KIND_MUL) begin
      if (entries < 2) begin
        res.status = ST_SHORT;
        entries = 0;
      end else begin
        rhs     = words[entries-1];
        lhs     = words[entries-2];
        lhs_mag = lhs[WORD_W-1] ? -lhs : lhs;
        rhs_mag = rhs[WORD_W-1] ? -rhs : rhs;
        if ((kind == KIND_DIV || kind == KIND_MOD) && rhs == '0) begin
          res.status = ST_DIVZERO;
          entries = 0;
        end else begin
          case (kind)
            KIND_ADD: value = lhs + rhs;
            KIND_SUB: value = lhs - rhs;
            KIND_MUL: value = lhs * rhs;
            KIND_DIV: begin
              // Unsigned divide of magnitudes, then the sign of the quotient.
              value = lhs_mag / rhs_mag;
              if (lhs[WORD_W-1] ^ rhs[WORD_W-1]) value = -value;
            end
            default: begin
              // The remainder follows the sign of the dividend.
              value = lhs_mag % rhs_mag;
              if (lhs[WORD_W-1]) value = -value;
            end
          endcase
          entries--;
          words[entries-1] = value;
        end
      end
    end
    res.top   = (entries > 0) ? words[entries-1] : '0;
    res.depth = DEPTH_W'(entries);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries = 0;
      fails   = 0;
      expected_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // The output side is handled first so that a result never meets the
      // expectation of a transaction accepted at the same edge.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, status %0d top %h depth %0d", $time,
                   m_axis_tuser_i, m_axis_tdata_i[WORD_W-1:0],
                   m_axis_tdata_i[WORD_W +: DEPTH_W]);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tuser_i !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status,
                     m_axis_tuser_i);
            fails++;
          end
          if (m_axis_tdata_i[WORD_W-1:0] !== want.top) begin
            $display("%0t: top_value expected %h, got %h", $time, want.top,
                     m_axis_tdata_i[WORD_W-1:0]);
            fails++;
          end
          if (m_axis_tdata_i[WORD_W +: DEPTH_W] !== want.depth) begin
            $display("%0t: stack_depth expected %0d, got %0d", $time, want.depth,
                     m_axis_tdata_i[WORD_W +: DEPTH_W]);
            fails++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_q.push_back(apply_item(s_axis_tuser_i, s_axis_tdata_i[WORD_W-1:0]));
      end
      fail_count_o <= fails;
      pending_o    <= expected_q.size();
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_stack_arithmetic_unit.sv =====
// Testbench top for stack_arithmetic_unit: drives directed and random operation
// streams with random idling on both sides and reports the verdict.
// Depends on sau_pkg, stack_arithmetic_unit and stack_result_checker.
`default_nettype none

module tb_stack_arithmetic_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import sau_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  localparam logic [WORD_W-1:0] MOST_NEG      = 32'h8000_0000;
  localparam logic [WORD_W-1:0] MOST_POS      = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] ALL_ONES      = 32'hFFFF_FFFF;
  localparam int                RANDOM_ITEMS  = 1620;
  localparam int                HOLD_CYCLES   = 300;
  localparam int                SETTLE_CYCLES = 60;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
  logic [KIND_W-1:0]       s_axis_tuser  = '0;
  logic                    m_axis_tready = 1'b0;
  wire logic               s_axis_tready;
  wire logic               m_axis_tvalid;
  wire logic [OUT_TDATA_W-1:0] m_axis_tdata;
  wire logic [STATUS_W-1:0]    m_axis_tuser;

  int fail_count;
  int pending;
  int items_sent    = 0;
  int hold_requests = 0;
  bit tx_calm       = 1'b0;

  stack_arithmetic_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  stack_result_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("stack_arithmetic_unit test failed");
    $finish;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_cycles();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      case ($urandom_range(0, 4))
        0: return '0;
        1: return 32'd1;
        2: return ALL_ONES;
        3: return MOST_NEG;
        default: return MOST_POS;
      endcase
    end
    if (roll < 60) return WORD_W'($signed($urandom_range(0, 40)) - 20);
    return $urandom;
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] word);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    gap = tx_calm ? 0 : idle_cycles();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stops offering transactions until every expected result has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Pushes a few operands and folds part of them, like evaluating an expression.
  task automatic run_expression();
    int operands;
    int ops;
    operands = $urandom_range(2, 10);
    ops      = $urandom_range(1, operands - 1);
    repeat (operands) send_item(KIND_PUSH, pick_word());
    repeat (ops) send_item(KIND_W'($urandom_range(KIND_ADD, KIND_MUL)), pick_word());
  endtask

  task automatic fill_stack();
    repeat ($urandom_range(STACK_DEPTH, STACK_DEPTH + 6)) send_item(KIND_PUSH, pick_word());
  endtask

  initial begin : receiver
    int  served;
    int  gap;
    bit  rx_calm;
    served  = 0;
    rx_calm = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
      gap = idle_cycles();
      if (hold_requests != served) begin
        served = hold_requests;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!rx_calm && gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int roll;
    int goal;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Short stacks, wrapping arithmetic, signed division and zero divisors.
    send_item(KIND_ADD, ALL_ONES);
    send_item(KIND_PUSH, 32'd7);
    send_item(KIND_MUL, '0);
    send_item(KIND_PUSH, MOST_NEG);
    send_item(KIND_PUSH, ALL_ONES);
    send_item(KIND_DIV, '0);
    send_item(KIND_PUSH, ALL_ONES);
    send_item(KIND_MOD, ALL_ONES);
    send_item(KIND_PUSH, MOST_POS);
    send_item(KIND_ADD, '0);
    send_item(KIND_PUSH, 32'd1);
    send_item(KIND_ADD, MOST_NEG);
    send_item(KIND_PUSH, 32'd1);
    send_item(KIND_SUB, '0);
    send_item(KIND_PUSH, -32'sd7);
    send_item(KIND_PUSH, 32'd2);
    send_item(KIND_DIV, '0);
    send_item(KIND_PUSH, 32'd2);
    send_item(KIND_MOD, '0);
    send_item(KIND_MUL, '0);
    send_item(KIND_SPARE_LO, ALL_ONES);
    send_item(KIND_PUSH, '0);
    send_item(KIND_MOD, '0);
    send_item(KIND_SPARE_HI, MOST_POS);
    send_item(KIND_PUSH, 32'd5);
    send_item(KIND_PUSH, '0);
    send_item(KIND_DIV, '0);
    drain();

    // The output side stalls long enough for the input to back up.
    hold_requests <= hold_requests + 1;
    repeat (20) send_item(KIND_PUSH, pick_word());
    drain();
    fill_stack();
    run_expression();

    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
        run_expression();
      end else if (roll < 88) begin
        send_item(KIND_W'($urandom_range(KIND_PUSH, KIND_SPARE_HI)), pick_word());
      end else if (roll < 92) begin
        fill_stack();
      end else if (roll < 95) begin
        drain();
      end else if (roll < 97) begin
        hold_requests <= hold_requests + 1;
        repeat (12) send_item(KIND_PUSH, pick_word());
      end else begin
        tx_calm = !tx_calm;
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("stack_arithmetic_unit test passed");
    end else begin
      $display("stack_arithmetic_unit test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/sau_pkg.sv
hdl/sau_ctrl.sv
hdl/sau_dpath.sv
hdl/stack_arithmetic_unit.sv
tb/stack_result_checker.sv
tb/tb_stack_arithmetic_unit.sv
